@@ src/bcle_pkg.sv @@
// bcle_pkg: shared types and codes for the bounded circular list engine
// word layouts, opcodes, status codes, controller states and command/status bundles
// depends on nothing; the datapath, controller and top files refer to it by scoped names
`default_nettype none

package bcle_pkg;

    // input word: one request
    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [31:0] value;
    } t_in_word;

    // output word: one result
    typedef struct packed {
        logic        [2:0]  status;
        logic        [5:0]  count;
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
    } t_out_word;

    // request opcodes
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_RM_FRONT  = 3'd2,
        OP_RM_BACK   = 3'd3,
        OP_RM_AFTER  = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NOAFTER  = 3'd4
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_POP,
        S_INS_WR1,
        S_INS_WR2,
        S_RMF_LINK,
        S_RMF_HEAD,
        S_RMB_WALK,
        S_RMB_TAIL,
        S_RMA_WALK,
        S_RMA_CUT,
        S_DONE
    } t_state;

    // read address source for the value and link memories
    typedef enum logic [1:0] {
        RS_FRONT,
        RS_CUR,
        RS_LINK
    } t_rsel;

    // link write address source
    typedef enum logic [1:0] {
        LWA_SLOT,
        LWA_BACK,
        LWA_CUR
    } t_lwa;

    // link write data source
    typedef enum logic [1:0] {
        LWD_SLOT,
        LWD_FRONT,
        LWD_LINK
    } t_lwd;

    // slot returned to the free stack
    typedef enum logic [1:0] {
        PS_FRONT,
        PS_BACK,
        PS_NXT
    } t_psel;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        t_rsel   rsel;
        logic    val_we;
        logic    link_we;
        t_lwa    lwa;
        t_lwd    lwd;
        logic    push;
        t_psel   psel;
        logic    slot_pop;
        logic    slot_fresh;
        logic    front_ld;
        logic    front_from_link;
        logic    back_ld;
        logic    back_from_cur;
        logic    head_ld;
        logic    head_from_ram;
        logic    tail_ld;
        logic    tail_from_ram;
        logic    cur_ld;
        logic    cur_from_link;
        logic    nxt_ld;
        logic    steps_clr;
        logic    steps_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    clear_all;
        logic    st_ld;
        t_status st_code;
        logic    out_ld;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       cnt_zero;
        logic       cnt_one;
        logic       full;
        logic       free_empty;
        logic       walk_last;
        logic       scan_end;
        logic       match;
        logic       cur_is_back;
        logic       nxt_is_back;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ src/bcle_ram.sv @@
// bcle_ram: generic simple dual-port memory, one write port and one registered read port
// no dependencies
`default_nettype none

module bcle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/bcle_dp.sv @@
// bcle_dp: datapath of the list engine: value, link and free-slot memories,
// list pointers, counters, cached end values and the output word register
// depends on bcle_pkg and bcle_ram
`default_nettype none

module bcle_dp #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bcle_pkg::t_in_word  i_in_word,
    input  wire bcle_pkg::t_cmd      i_cmd,
    output      bcle_pkg::t_sts      o_sts,
    output      logic                o_out_valid,
    output      bcle_pkg::t_out_word o_out_word,
    input  wire logic                i_out_stall
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = DATA_WIDTH;

    // captured request
    logic [2:0]    r_op;
    logic [DW-1:0] r_val;

    // list state
    logic [AW-1:0] r_front, r_back, r_cur, r_nxt, r_slot;
    logic [CW-1:0] r_count, r_steps, r_fresh, r_ftop;
    logic [DW-1:0] r_head, r_tail;
    bcle_pkg::t_status r_status;

    // output register
    logic                r_out_valid;
    bcle_pkg::t_out_word r_out_word;
    bcle_pkg::t_out_word n_out_word;

    // memory ports
    logic [DW-1:0] val_rdata;
    logic [AW-1:0] link_rdata, free_rdata;
    logic [AW-1:0] rd_addr, lw_addr, lw_data, fw_data, fr_addr;
    logic [CW-1:0] ftop_m1;

    // width adaptation
    logic [DW+31:0] val_ext;
    logic [CW+5:0]  cnt_ext;
    logic [DW+31:0] head_ext, tail_ext;
    logic [CW:0]    steps_p2, steps_p1;

    assign val_ext  = {{DW{i_in_word.value[31]}}, i_in_word.value};
    assign cnt_ext  = {6'd0, r_count};
    assign head_ext = {{32{r_head[DW-1]}}, r_head};
    assign tail_ext = {{32{r_tail[DW-1]}}, r_tail};
    assign steps_p2 = {1'b0, r_steps} + (CW+1)'(2);
    assign steps_p1 = {1'b0, r_steps} + (CW+1)'(1);
    assign ftop_m1  = r_ftop - CW'(1);
    assign fr_addr  = ftop_m1[AW-1:0];

    // read address select, shared by value and link memories
    always_comb begin
        case (i_cmd.rsel)
            bcle_pkg::RS_FRONT: rd_addr = r_front;
            bcle_pkg::RS_CUR:   rd_addr = r_cur;
            bcle_pkg::RS_LINK:  rd_addr = link_rdata;
            default:            rd_addr = r_front;
        endcase
    end

    // link write address and data
    always_comb begin
        case (i_cmd.lwa)
            bcle_pkg::LWA_SLOT: lw_addr = r_slot;
            bcle_pkg::LWA_BACK: lw_addr = r_back;
            bcle_pkg::LWA_CUR:  lw_addr = r_cur;
            default:            lw_addr = r_slot;
        endcase
        case (i_cmd.lwd)
            bcle_pkg::LWD_SLOT:  lw_data = r_slot;
            bcle_pkg::LWD_FRONT: lw_data = r_front;
            bcle_pkg::LWD_LINK:  lw_data = link_rdata;
            default:             lw_data = r_slot;
        endcase
        case (i_cmd.psel)
            bcle_pkg::PS_FRONT: fw_data = r_front;
            bcle_pkg::PS_BACK:  fw_data = r_back;
            bcle_pkg::PS_NXT:   fw_data = r_nxt;
            default:            fw_data = r_front;
        endcase
    end

    // element values
    bcle_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.val_we),
        .i_waddr (r_slot),
        .i_wdata (r_val),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    // element links
    bcle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.link_we),
        .i_waddr (lw_addr),
        .i_wdata (lw_data),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    // stack of released slots; never-used slots come from the fresh counter
    bcle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_ftop[AW-1:0]),
        .i_wdata (fw_data),
        .i_raddr (fr_addr),
        .o_rdata (free_rdata)
    );

    // control registers: count, slot pool, end pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fresh <= '0;
            r_ftop  <= '0;
            r_front <= '0;
            r_back  <= '0;
        end else begin
            if (i_cmd.clear_all) begin
                r_count <= '0;
                r_fresh <= '0;
                r_ftop  <= '0;
            end else begin
                if (i_cmd.cnt_inc) begin
                    r_count <= r_count + CW'(1);
                end else if (i_cmd.cnt_dec) begin
                    r_count <= r_count - CW'(1);
                end
                if (i_cmd.slot_fresh) begin
                    r_fresh <= r_fresh + CW'(1);
                end
                if (i_cmd.push) begin
                    r_ftop <= r_ftop + CW'(1);
                end else if (i_cmd.slot_pop) begin
                    r_ftop <= ftop_m1;
                end
            end
            if (i_cmd.front_ld) begin
                r_front <= i_cmd.front_from_link ? link_rdata : r_slot;
            end
            if (i_cmd.back_ld) begin
                r_back <= i_cmd.back_from_cur ? r_cur : r_slot;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_word.opcode;
            r_val <= val_ext[DW-1:0];
        end
        if (i_cmd.slot_pop) begin
            r_slot <= free_rdata;
        end else if (i_cmd.slot_fresh) begin
            r_slot <= r_fresh[AW-1:0];
        end
        if (i_cmd.head_ld) begin
            r_head <= i_cmd.head_from_ram ? val_rdata : r_val;
        end
        if (i_cmd.tail_ld) begin
            r_tail <= i_cmd.tail_from_ram ? val_rdata : r_val;
        end
        if (i_cmd.cur_ld) begin
            r_cur <= i_cmd.cur_from_link ? link_rdata : r_front;
        end
        if (i_cmd.nxt_ld) begin
            r_nxt <= link_rdata;
        end
        if (i_cmd.steps_clr) begin
            r_steps <= '0;
        end else if (i_cmd.steps_inc) begin
            r_steps <= r_steps + CW'(1);
        end
        if (i_cmd.st_ld) begin
            r_status <= i_cmd.st_code;
        end
    end

    // result word from the state after the operation
    always_comb begin
        n_out_word.status = r_status;
        n_out_word.count  = cnt_ext[5:0];
        if (r_count == '0) begin
            n_out_word.head_value = '0;
            n_out_word.tail_value = '0;
        end else begin
            n_out_word.head_value = head_ext[31:0];
            n_out_word.tail_value = tail_ext[31:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // status to the controller
    always_comb begin
        o_sts.op          = r_op;
        o_sts.cnt_zero    = (r_count == '0);
        o_sts.cnt_one     = (r_count == CW'(1));
        o_sts.full        = (r_count == CW'(CAPACITY));
        o_sts.free_empty  = (r_ftop == '0);
        o_sts.walk_last   = (steps_p2 == {1'b0, r_count});
        o_sts.scan_end    = (steps_p1 == {1'b0, r_count});
        o_sts.match       = (val_rdata == r_val);
        o_sts.cur_is_back = (r_cur == r_back);
        o_sts.nxt_is_back = (link_rdata == r_back);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

@@ src/bcle_ctrl.sv @@
// bcle_ctrl: controller state machine of the list engine
// sequences memory accesses and register loads for each request
// depends on bcle_pkg
`default_nettype none

module bcle_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_stall,
    input  wire bcle_pkg::t_sts i_sts,
    output      bcle_pkg::t_cmd o_cmd
);

    bcle_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != bcle_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            bcle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bcle_pkg::S_DISPATCH;
                end
            end

            // decode the captured request
            bcle_pkg::S_DISPATCH: begin
                case (i_sts.op)
                    bcle_pkg::OP_INS_FRONT, bcle_pkg::OP_INS_BACK: begin
                        if (i_sts.full) begin
                            o_cmd.st_ld   = 1'b1;
                            o_cmd.st_code = bcle_pkg::ST_FULL;
                            n_state       = bcle_pkg::S_DONE;
                        end else if (!i_sts.free_empty) begin
                            n_state = bcle_pkg::S_INS_POP;
                        end else begin
                            o_cmd.slot_fresh = 1'b1;
                            n_state          = bcle_pkg::S_INS_WR1;
                        end
                    end
                    bcle_pkg::OP_RM_FRONT, bcle_pkg::OP_RM_BACK: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.st_ld   = 1'b1;
                            o_cmd.st_code = bcle_pkg::ST_EMPTY;
                            n_state       = bcle_pkg::S_DONE;
                        end else if (i_sts.cnt_one) begin
                            o_cmd.push    = 1'b1;
                            o_cmd.psel    = bcle_pkg::PS_FRONT;
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.st_ld   = 1'b1;
                            o_cmd.st_code = bcle_pkg::ST_OK;
                            n_state       = bcle_pkg::S_DONE;
                        end else if (i_sts.op == bcle_pkg::OP_RM_FRONT) begin
                            o_cmd.rsel = bcle_pkg::RS_FRONT;
                            n_state    = bcle_pkg::S_RMF_LINK;
                        end else begin
                            o_cmd.rsel      = bcle_pkg::RS_FRONT;
                            o_cmd.cur_ld    = 1'b1;
                            o_cmd.steps_clr = 1'b1;
                            n_state         = bcle_pkg::S_RMB_WALK;
                        end
                    end
                    bcle_pkg::OP_RM_AFTER: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.st_ld   = 1'b1;
                            o_cmd.st_code = bcle_pkg::ST_EMPTY;
                            n_state       = bcle_pkg::S_DONE;
                        end else begin
                            o_cmd.rsel      = bcle_pkg::RS_FRONT;
                            o_cmd.cur_ld    = 1'b1;
                            o_cmd.steps_clr = 1'b1;
                            n_state         = bcle_pkg::S_RMA_WALK;
                        end
                    end
                    bcle_pkg::OP_CLEAR: begin
                        o_cmd.st_ld = 1'b1;
                        if (i_sts.cnt_zero) begin
                            o_cmd.st_code = bcle_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.clear_all = 1'b1;
                            o_cmd.st_code   = bcle_pkg::ST_OK;
                        end
                        n_state = bcle_pkg::S_DONE;
                    end
                    default: begin
                        o_cmd.st_ld   = 1'b1;
                        o_cmd.st_code = bcle_pkg::ST_OK;
                        n_state       = bcle_pkg::S_DONE;
                    end
                endcase
            end

            // take a released slot off the free stack
            bcle_pkg::S_INS_POP: begin
                o_cmd.slot_pop = 1'b1;
                n_state        = bcle_pkg::S_INS_WR1;
            end

            // write the new element and its link
            bcle_pkg::S_INS_WR1: begin
                o_cmd.val_we  = 1'b1;
                o_cmd.link_we = 1'b1;
                o_cmd.lwa     = bcle_pkg::LWA_SLOT;
                if (i_sts.cnt_zero) begin
                    o_cmd.lwd      = bcle_pkg::LWD_SLOT;
                    o_cmd.front_ld = 1'b1;
                    o_cmd.back_ld  = 1'b1;
                    o_cmd.head_ld  = 1'b1;
                    o_cmd.tail_ld  = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.st_ld    = 1'b1;
                    o_cmd.st_code  = bcle_pkg::ST_OK;
                    n_state        = bcle_pkg::S_DONE;
                end else begin
                    o_cmd.lwd = bcle_pkg::LWD_FRONT;
                    n_state   = bcle_pkg::S_INS_WR2;
                end
            end

            // close the ring through the old back
            bcle_pkg::S_INS_WR2: begin
                o_cmd.link_we = 1'b1;
                o_cmd.lwa     = bcle_pkg::LWA_BACK;
                o_cmd.lwd     = bcle_pkg::LWD_SLOT;
                if (i_sts.op == bcle_pkg::OP_INS_FRONT) begin
                    o_cmd.front_ld = 1'b1;
                    o_cmd.head_ld  = 1'b1;
                end else begin
                    o_cmd.back_ld = 1'b1;
                    o_cmd.tail_ld = 1'b1;
                end
                o_cmd.cnt_inc = 1'b1;
                o_cmd.st_ld   = 1'b1;
                o_cmd.st_code = bcle_pkg::ST_OK;
                n_state       = bcle_pkg::S_DONE;
            end

            // unlink the front, fetch the new front value
            bcle_pkg::S_RMF_LINK: begin
                o_cmd.link_we         = 1'b1;
                o_cmd.lwa             = bcle_pkg::LWA_BACK;
                o_cmd.lwd             = bcle_pkg::LWD_LINK;
                o_cmd.push            = 1'b1;
                o_cmd.psel            = bcle_pkg::PS_FRONT;
                o_cmd.front_ld        = 1'b1;
                o_cmd.front_from_link = 1'b1;
                o_cmd.rsel            = bcle_pkg::RS_LINK;
                o_cmd.cnt_dec         = 1'b1;
                n_state               = bcle_pkg::S_RMF_HEAD;
            end

            bcle_pkg::S_RMF_HEAD: begin
                o_cmd.head_ld       = 1'b1;
                o_cmd.head_from_ram = 1'b1;
                o_cmd.st_ld         = 1'b1;
                o_cmd.st_code       = bcle_pkg::ST_OK;
                n_state             = bcle_pkg::S_DONE;
            end

            // walk to the element before the back, one link per cycle
            bcle_pkg::S_RMB_WALK: begin
                if (i_sts.walk_last) begin
                    o_cmd.push          = 1'b1;
                    o_cmd.psel          = bcle_pkg::PS_BACK;
                    o_cmd.back_ld       = 1'b1;
                    o_cmd.back_from_cur = 1'b1;
                    o_cmd.link_we       = 1'b1;
                    o_cmd.lwa           = bcle_pkg::LWA_CUR;
                    o_cmd.lwd           = bcle_pkg::LWD_FRONT;
                    o_cmd.rsel          = bcle_pkg::RS_CUR;
                    o_cmd.cnt_dec       = 1'b1;
                    n_state             = bcle_pkg::S_RMB_TAIL;
                end else begin
                    o_cmd.cur_ld        = 1'b1;
                    o_cmd.cur_from_link = 1'b1;
                    o_cmd.rsel          = bcle_pkg::RS_LINK;
                    o_cmd.steps_inc     = 1'b1;
                end
            end

            bcle_pkg::S_RMB_TAIL: begin
                o_cmd.tail_ld       = 1'b1;
                o_cmd.tail_from_ram = 1'b1;
                o_cmd.st_ld         = 1'b1;
                o_cmd.st_code       = bcle_pkg::ST_OK;
                n_state             = bcle_pkg::S_DONE;
            end

            // scan for the first match, one element per cycle
            bcle_pkg::S_RMA_WALK: begin
                if (i_sts.match) begin
                    if (i_sts.cur_is_back) begin
                        o_cmd.st_ld   = 1'b1;
                        o_cmd.st_code = bcle_pkg::ST_NOAFTER;
                        n_state       = bcle_pkg::S_DONE;
                    end else begin
                        o_cmd.nxt_ld = 1'b1;
                        o_cmd.rsel   = bcle_pkg::RS_LINK;
                        if (i_sts.nxt_is_back) begin
                            o_cmd.back_ld       = 1'b1;
                            o_cmd.back_from_cur = 1'b1;
                            o_cmd.tail_ld       = 1'b1;
                            o_cmd.tail_from_ram = 1'b1;
                        end
                        n_state = bcle_pkg::S_RMA_CUT;
                    end
                end else if (i_sts.scan_end) begin
                    o_cmd.st_ld   = 1'b1;
                    o_cmd.st_code = bcle_pkg::ST_NOTFOUND;
                    n_state       = bcle_pkg::S_DONE;
                end else begin
                    o_cmd.cur_ld        = 1'b1;
                    o_cmd.cur_from_link = 1'b1;
                    o_cmd.rsel          = bcle_pkg::RS_LINK;
                    o_cmd.steps_inc     = 1'b1;
                end
            end

            // bypass the element after the match
            bcle_pkg::S_RMA_CUT: begin
                o_cmd.link_we = 1'b1;
                o_cmd.lwa     = bcle_pkg::LWA_CUR;
                o_cmd.lwd     = bcle_pkg::LWD_LINK;
                o_cmd.push    = 1'b1;
                o_cmd.psel    = bcle_pkg::PS_NXT;
                o_cmd.cnt_dec = 1'b1;
                o_cmd.st_ld   = 1'b1;
                o_cmd.st_code = bcle_pkg::ST_OK;
                n_state       = bcle_pkg::S_DONE;
            end

            // hand the result to the output register
            bcle_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = bcle_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bcle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/bounded_circular_list_engine_top.sv @@
// Bounded circular list engine, top level.
// Request channel: i_in_valid / o_in_stall with i_in_word (opcode, value). A word is
// taken at a rising edge with i_in_valid high and o_in_stall low.
// Result channel: o_out_valid / i_out_stall with o_out_word (status, count, head and
// tail value). Exactly one result word per request, in request order.
// One request is worked at a time; o_in_stall is low only while the engine is idle.
// Refused, clear, unknown and single-element removals are settled at dispatch; an
// insert may first pop a reused slot, then writes the element and, into a non-empty
// list, closes the ring; remove front unlinks the front and fetches the new head
// value; remove back and remove after match walk the list.
// The walks follow links through the link memory one entry per cycle, so the
// scan over the list sets the worst case.
// A finished result sits in an output register; the next request is taken while
// it waits, and the engine holds the following result until the register frees.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result;
// the memories need no clearing pass.
// depends on bcle_pkg, bcle_ctrl, bcle_dp, bcle_ram
`default_nettype none

module bounded_circular_list_engine_top #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire bcle_pkg::t_in_word  i_in_word,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      bcle_pkg::t_out_word o_out_word
);

    bcle_pkg::t_cmd cmd;
    bcle_pkg::t_sts sts;

    // controller
    bcle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    bcle_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
